FILE: sv/rau_pkg.sv
`timescale 1ns / 1ps
package rau_pkg;

  // Datapath word: holds exact intermediate products of two 32-bit magnitudes
  localparam int DataW    = 64;
  localparam int MulW     = 32;
  localparam int InDataW  = 136;
  localparam int OutDataW = 72;
  localparam int DefWidth = 32;

  // Command codes of an input request
  localparam logic [2:0] CMD_ADD = 3'd0;
  localparam logic [2:0] CMD_SUB = 3'd1;
  localparam logic [2:0] CMD_MUL = 3'd2;
  localparam logic [2:0] CMD_DIV = 3'd3;
  localparam logic [2:0] CMD_CMP = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ZDEN  = 2'd1;
  localparam logic [1:0] ST_DZERO = 2'd2;
  localparam logic [1:0] ST_OVF   = 2'd3;

  // Compare codes
  localparam logic [1:0] ORD_LT = 2'd0;
  localparam logic [1:0] ORD_EQ = 2'd1;
  localparam logic [1:0] ORD_GT = 2'd2;

  typedef enum logic [2:0] {
    OP_NOP, OP_LOAD, OP_GCD, OP_DIV2, OP_MUL, OP_COMB, OP_SIGN, OP_FIN
  } op_e;

  typedef enum logic [2:0] {
    RG_AM, RG_AD, RG_BM, RG_BD, RG_RM, RG_RD, RG_T1, RG_T2
  } reg_e;

  typedef enum logic [2:0] {
    FK_NONE, FK_ZDEN, FK_DZERO, FK_CMP, FK_ARITH
  } fin_e;

  typedef struct packed {
    logic start;
    op_e  op;
    reg_e sx;
    reg_e sy;
    reg_e dx;
    reg_e dy;
    fin_e fin;
  } dp_cmd_t;

  typedef struct packed {
    logic       done;
    logic [2:0] cmd;
    logic       zero_den;
    logic       b_zero;
  } dp_stat_t;

endpackage

FILE: sv/rau_gcd.sv
`timescale 1ns / 1ps
// Binary gcd, one subtract-and-shift step per cycle. y must be nonzero.
module rau_gcd (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [rau_pkg::DataW-1:0]  x_i,
  input  logic [rau_pkg::DataW-1:0]  y_i,
  output logic                       done_o,
  output logic [rau_pkg::DataW-1:0]  g_o
);

  localparam int KW = $clog2(rau_pkg::DataW);

  logic                      busy_q, phase_q, done_q;
  logic [rau_pkg::DataW-1:0] u_q, v_q;
  logic [KW-1:0]             k_q;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q  <= 1'b1;
        phase_q <= 1'b0;
      end else if (busy_q) begin
        if (!phase_q) begin
          if (u_q[0] || v_q[0]) phase_q <= 1'b1;
        end else if (u_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // operands: strip common twos, then Stein steps
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      u_q <= x_i;
      v_q <= y_i;
      k_q <= '0;
    end else if (busy_q) begin
      if (!phase_q) begin
        if (!u_q[0] && !v_q[0]) begin
          u_q <= u_q >> 1;
          v_q <= v_q >> 1;
          k_q <= k_q + KW'(1);
        end
      end else if (u_q != '0) begin
        if (!u_q[0])          u_q <= u_q >> 1;
        else if (!v_q[0])     v_q <= v_q >> 1;
        else if (u_q >= v_q)  u_q <= (u_q - v_q) >> 1;
        else                  v_q <= (v_q - u_q) >> 1;
      end
    end
  end

  assign done_o = done_q;
  assign g_o    = v_q << k_q;

endmodule

FILE: sv/rau_div2.sv
`timescale 1ns / 1ps
// Two restoring dividers sharing one divisor, one quotient bit per cycle.
module rau_div2 (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [rau_pkg::DataW-1:0]  a_i,
  input  logic [rau_pkg::DataW-1:0]  b_i,
  input  logic [rau_pkg::DataW-1:0]  d_i,
  output logic                       done_o,
  output logic [rau_pkg::DataW-1:0]  qa_o,
  output logic [rau_pkg::DataW-1:0]  qb_o
);

  localparam int W  = rau_pkg::DataW;
  localparam int CW = $clog2(W);

  logic          busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  ra_q, rb_q, qa_q, qb_q, dv_q;
  logic [W:0]    sa, sb, da, db;
  logic          ga, gb;

  // one restoring step per lane
  always_comb begin
    sa = {ra_q, qa_q[W-1]};
    sb = {rb_q, qb_q[W-1]};
    ga = sa >= {1'b0, dv_q};
    gb = sb >= {1'b0, dv_q};
    da = ga ? sa - {1'b0, dv_q} : sa;
    db = gb ? sb - {1'b0, dv_q} : sb;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ra_q <= '0;
      rb_q <= '0;
      qa_q <= a_i;
      qb_q <= b_i;
      dv_q <= d_i;
    end else if (busy_q) begin
      ra_q <= da[W-1:0];
      rb_q <= db[W-1:0];
      qa_q <= {qa_q[W-2:0], ga};
      qb_q <= {qb_q[W-2:0], gb};
    end
  end

  assign done_o = done_q;
  assign qa_o   = qa_q;
  assign qb_o   = qb_q;

endmodule

FILE: sv/rau_datapath.sv
`timescale 1ns / 1ps
module rau_datapath #(
  parameter int WIDTH = rau_pkg::DefWidth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rau_pkg::dp_cmd_t              cmd_i,
  output rau_pkg::dp_stat_t             stat_o,
  input  logic [rau_pkg::InDataW-1:0]   in_data_i,
  output logic [rau_pkg::OutDataW-1:0]  out_data_o
);

  localparam int W = rau_pkg::DataW;
  localparam logic [W-1:0] Lim = W'(1) << (WIDTH - 1);

  logic [W-1:0] am_q, ad_q, bm_q, bd_q, rm_q, rd_q, t1_q, t2_q;
  logic         a_neg_q, b_neg_q, r_neg_q;
  logic [2:0]   cmd_q;
  logic [31:0]  res_num_q;
  logic [30:0]  res_den_q;
  logic [1:0]   ord_q, st_q;

  logic [W-1:0] xv, yv, g, qa, qb, prod, ta, tb;
  logic         gcd_go, div_go, gcd_done, div_done;
  logic         bneg, over, sx, sy;
  logic [W-1:0] cmb_mag;
  logic         cmb_neg;
  logic [31:0]  an_in, ad_in, bn_in, bd_in;
  logic [1:0]   cmp_ord;

  // operand select
  function automatic logic [W-1:0] sel(input rau_pkg::reg_e s, input logic [W-1:0] am,
      input logic [W-1:0] ad, input logic [W-1:0] bm, input logic [W-1:0] bd,
      input logic [W-1:0] rm, input logic [W-1:0] rd, input logic [W-1:0] t1,
      input logic [W-1:0] t2);
    logic [W-1:0] v;
    case (s)
      rau_pkg::RG_AM: v = am;
      rau_pkg::RG_AD: v = ad;
      rau_pkg::RG_BM: v = bm;
      rau_pkg::RG_BD: v = bd;
      rau_pkg::RG_RM: v = rm;
      rau_pkg::RG_RD: v = rd;
      rau_pkg::RG_T1: v = t1;
      rau_pkg::RG_T2: v = t2;
      default:        v = am;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  assign xv = sel(cmd_i.sx, am_q, ad_q, bm_q, bd_q, rm_q, rd_q, t1_q, t2_q);
  assign yv = sel(cmd_i.sy, am_q, ad_q, bm_q, bd_q, rm_q, rd_q, t1_q, t2_q);

  assign gcd_go = cmd_i.start && (cmd_i.op == rau_pkg::OP_GCD);
  assign div_go = cmd_i.start && (cmd_i.op == rau_pkg::OP_DIV2);

  rau_gcd u_gcd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(gcd_go),
    .x_i    (xv),
    .y_i    (yv),
    .done_o (gcd_done),
    .g_o    (g)
  );

  rau_div2 u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_go),
    .a_i    (xv),
    .b_i    (yv),
    .d_i    (g),
    .done_o (div_done),
    .qa_o   (qa),
    .qb_o   (qb)
  );

  // 32x32 product, registered into its destination
  assign prod = W'(xv[rau_pkg::MulW-1:0]) * W'(yv[rau_pkg::MulW-1:0]);

  // input fields
  assign an_in = in_data_i[34:3];
  assign ad_in = in_data_i[66:35];
  assign bn_in = in_data_i[98:67];
  assign bd_in = in_data_i[130:99];

  // signed add of scaled numerators
  always_comb begin
    ta   = am_q;
    tb   = bm_q;
    bneg = (cmd_q == rau_pkg::CMD_SUB) ? !b_neg_q : b_neg_q;
    if (a_neg_q == bneg) begin
      cmb_neg = a_neg_q;
      cmb_mag = ta + tb;
    end else if (ta >= tb) begin
      cmb_neg = a_neg_q;
      cmb_mag = ta - tb;
    end else begin
      cmb_neg = bneg;
      cmb_mag = tb - ta;
    end
  end

  // exact compare of cross products
  always_comb begin
    sx = a_neg_q && (t1_q != '0);
    sy = b_neg_q && (t2_q != '0);
    if (sx != sy)        cmp_ord = sx ? rau_pkg::ORD_LT : rau_pkg::ORD_GT;
    else if (t1_q == t2_q) cmp_ord = rau_pkg::ORD_EQ;
    else if (sx)         cmp_ord = (t1_q > t2_q) ? rau_pkg::ORD_LT : rau_pkg::ORD_GT;
    else                 cmp_ord = (t1_q > t2_q) ? rau_pkg::ORD_GT : rau_pkg::ORD_LT;
  end

  assign over = (rd_q >= Lim) || (r_neg_q ? (rm_q > Lim) : (rm_q >= Lim));

  // register file writes
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      case (cmd_i.op)
        rau_pkg::OP_LOAD: begin
          cmd_q   <= in_data_i[2:0];
          am_q    <= W'(mag32(an_in));
          ad_q    <= W'(mag32(ad_in));
          bm_q    <= W'(mag32(bn_in));
          bd_q    <= W'(mag32(bd_in));
          a_neg_q <= an_in[31] ^ ad_in[31];
          b_neg_q <= bn_in[31] ^ bd_in[31];
        end
        rau_pkg::OP_MUL: begin
          case (cmd_i.dx)
            rau_pkg::RG_AM: am_q <= prod;
            rau_pkg::RG_AD: ad_q <= prod;
            rau_pkg::RG_BM: bm_q <= prod;
            rau_pkg::RG_BD: bd_q <= prod;
            rau_pkg::RG_RM: rm_q <= prod;
            rau_pkg::RG_RD: rd_q <= prod;
            rau_pkg::RG_T1: t1_q <= prod;
            rau_pkg::RG_T2: t2_q <= prod;
            default: ;
          endcase
        end
        rau_pkg::OP_COMB: begin
          rm_q    <= cmb_mag;
          r_neg_q <= cmb_neg;
        end
        rau_pkg::OP_SIGN: r_neg_q <= a_neg_q ^ b_neg_q;
        rau_pkg::OP_FIN: begin
          res_num_q <= '0;
          res_den_q <= 31'd1;
          ord_q     <= rau_pkg::ORD_LT;
          case (cmd_i.fin)
            rau_pkg::FK_ZDEN:  st_q <= rau_pkg::ST_ZDEN;
            rau_pkg::FK_DZERO: st_q <= rau_pkg::ST_DZERO;
            rau_pkg::FK_CMP: begin
              st_q  <= rau_pkg::ST_OK;
              ord_q <= cmp_ord;
            end
            rau_pkg::FK_ARITH: begin
              if (over) begin
                st_q <= rau_pkg::ST_OVF;
              end else begin
                st_q      <= rau_pkg::ST_OK;
                res_num_q <= r_neg_q ? 32'(~rm_q + W'(1)) : rm_q[31:0];
                res_den_q <= rd_q[30:0];
              end
            end
            default: st_q <= rau_pkg::ST_OK;
          endcase
        end
        default: ;
      endcase
    end else if (div_done) begin
      case (cmd_i.dx)
        rau_pkg::RG_AM: am_q <= qa;
        rau_pkg::RG_BM: bm_q <= qa;
        rau_pkg::RG_RM: rm_q <= qa;
        rau_pkg::RG_T1: t1_q <= qa;
        default: ;
      endcase
      case (cmd_i.dy)
        rau_pkg::RG_AD: ad_q <= qb;
        rau_pkg::RG_BD: bd_q <= qb;
        rau_pkg::RG_RD: rd_q <= qb;
        rau_pkg::RG_T2: t2_q <= qb;
        default: ;
      endcase
    end
  end

  assign stat_o.done     = gcd_done | div_done;
  assign stat_o.cmd      = cmd_q;
  assign stat_o.zero_den = (ad_q == '0) || (bd_q == '0);
  assign stat_o.b_zero   = (bm_q == '0);

  // res_num, res_den, order, status from bit 0 up, zero padded
  assign out_data_o = {5'd0, st_q, ord_q, res_den_q, res_num_q};

endmodule

FILE: sv/rau_ctrl.sv
`timescale 1ns / 1ps
module rau_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rau_pkg::dp_cmd_t   cmd_o,
  input  rau_pkg::dp_stat_t  stat_i
);

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_RA_G, S_RA_D, S_RB_G, S_RB_D, S_DISP, S_L_G, S_L_D,
    S_M1, S_M2, S_M3, S_COMB, S_X1, S_X2, S_SIGN, S_R_G, S_R_D, S_FIN
  } state_e;

  state_e        state_q, state_d;
  logic          wait_q, wait_d, ov_q, ov_d;
  rau_pkg::fin_e fin_q, fin_d;
  logic          multi, issue, fire;
  state_e        nxt;

  // command per step
  always_comb begin
    cmd_o       = '0;
    cmd_o.op    = rau_pkg::OP_NOP;
    cmd_o.sx    = rau_pkg::RG_AM;
    cmd_o.sy    = rau_pkg::RG_AD;
    cmd_o.dx    = rau_pkg::RG_AM;
    cmd_o.dy    = rau_pkg::RG_AD;
    cmd_o.fin   = fin_q;
    multi       = 1'b0;
    nxt         = state_q;
    case (state_q)
      S_IDLE:  cmd_o.op = rau_pkg::OP_LOAD;
      S_RA_G: begin cmd_o.op = rau_pkg::OP_GCD; multi = 1'b1; nxt = S_RA_D; end
      S_RA_D: begin cmd_o.op = rau_pkg::OP_DIV2; multi = 1'b1; nxt = S_RB_G; end
      S_RB_G: begin
        cmd_o.op = rau_pkg::OP_GCD; cmd_o.sx = rau_pkg::RG_BM; cmd_o.sy = rau_pkg::RG_BD;
        multi = 1'b1; nxt = S_RB_D;
      end
      S_RB_D: begin
        cmd_o.op = rau_pkg::OP_DIV2; cmd_o.sx = rau_pkg::RG_BM; cmd_o.sy = rau_pkg::RG_BD;
        cmd_o.dx = rau_pkg::RG_BM; cmd_o.dy = rau_pkg::RG_BD; multi = 1'b1; nxt = S_DISP;
      end
      S_L_G: begin
        cmd_o.op = rau_pkg::OP_GCD; cmd_o.sx = rau_pkg::RG_AD; cmd_o.sy = rau_pkg::RG_BD;
        multi = 1'b1; nxt = S_L_D;
      end
      S_L_D: begin
        cmd_o.op = rau_pkg::OP_DIV2; cmd_o.sx = rau_pkg::RG_BD; cmd_o.sy = rau_pkg::RG_AD;
        cmd_o.dx = rau_pkg::RG_T1; cmd_o.dy = rau_pkg::RG_T2; multi = 1'b1; nxt = S_M1;
      end
      S_M1: begin
        cmd_o.op = rau_pkg::OP_MUL; cmd_o.sy = rau_pkg::RG_T1; nxt = S_M2;
      end
      S_M2: begin
        cmd_o.op = rau_pkg::OP_MUL; cmd_o.sx = rau_pkg::RG_BM; cmd_o.sy = rau_pkg::RG_T2;
        cmd_o.dx = rau_pkg::RG_BM; nxt = S_M3;
      end
      S_M3: begin
        cmd_o.op = rau_pkg::OP_MUL; cmd_o.sx = rau_pkg::RG_T2; cmd_o.sy = rau_pkg::RG_BD;
        cmd_o.dx = rau_pkg::RG_RD; nxt = S_COMB;
      end
      S_COMB: begin cmd_o.op = rau_pkg::OP_COMB; nxt = S_R_G; end
      S_X1: begin
        cmd_o.op = rau_pkg::OP_MUL;
        cmd_o.sy = (stat_i.cmd == rau_pkg::CMD_MUL) ? rau_pkg::RG_BM : rau_pkg::RG_BD;
        cmd_o.dx = (stat_i.cmd == rau_pkg::CMD_CMP) ? rau_pkg::RG_T1 : rau_pkg::RG_RM;
        nxt = S_X2;
      end
      S_X2: begin
        cmd_o.op = rau_pkg::OP_MUL;
        cmd_o.sx = (stat_i.cmd == rau_pkg::CMD_CMP) ? rau_pkg::RG_BM : rau_pkg::RG_AD;
        cmd_o.sy = (stat_i.cmd == rau_pkg::CMD_MUL) ? rau_pkg::RG_BD :
                   (stat_i.cmd == rau_pkg::CMD_DIV) ? rau_pkg::RG_BM : rau_pkg::RG_AD;
        cmd_o.dx = (stat_i.cmd == rau_pkg::CMD_CMP) ? rau_pkg::RG_T2 : rau_pkg::RG_RD;
        nxt = (stat_i.cmd == rau_pkg::CMD_CMP) ? S_FIN : S_SIGN;
      end
      S_SIGN: begin cmd_o.op = rau_pkg::OP_SIGN; nxt = S_R_G; end
      S_R_G: begin
        cmd_o.op = rau_pkg::OP_GCD; cmd_o.sx = rau_pkg::RG_RM; cmd_o.sy = rau_pkg::RG_RD;
        multi = 1'b1; nxt = S_R_D;
      end
      S_R_D: begin
        cmd_o.op = rau_pkg::OP_DIV2; cmd_o.sx = rau_pkg::RG_RM; cmd_o.sy = rau_pkg::RG_RD;
        cmd_o.dx = rau_pkg::RG_RM; cmd_o.dy = rau_pkg::RG_RD; multi = 1'b1; nxt = S_FIN;
      end
      S_FIN:   cmd_o.op = rau_pkg::OP_FIN;
      default: ;
    endcase

    fire        = !ov_q || out_ready_i;
    issue       = 1'b0;
    state_d     = state_q;
    wait_d      = wait_q;
    fin_d       = fin_q;
    ov_d        = ov_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        issue = in_valid_i;
        if (in_valid_i) state_d = S_CHECK;
      end
      S_CHECK: begin
        if (stat_i.cmd > rau_pkg::CMD_CMP) begin
          fin_d = rau_pkg::FK_NONE; state_d = S_FIN;
        end else if (stat_i.zero_den) begin
          fin_d = rau_pkg::FK_ZDEN; state_d = S_FIN;
        end else begin
          state_d = S_RA_G;
        end
      end
      S_DISP: begin
        case (stat_i.cmd)
          rau_pkg::CMD_ADD, rau_pkg::CMD_SUB: begin
            fin_d = rau_pkg::FK_ARITH; state_d = S_L_G;
          end
          rau_pkg::CMD_DIV: begin
            if (stat_i.b_zero) begin
              fin_d = rau_pkg::FK_DZERO; state_d = S_FIN;
            end else begin
              fin_d = rau_pkg::FK_ARITH; state_d = S_X1;
            end
          end
          rau_pkg::CMD_CMP: begin fin_d = rau_pkg::FK_CMP; state_d = S_X1; end
          default: begin fin_d = rau_pkg::FK_ARITH; state_d = S_X1; end
        endcase
      end
      S_FIN: begin
        issue = fire;
        if (fire) begin
          ov_d    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        if (!wait_q) begin
          issue = 1'b1;
          if (multi) wait_d = 1'b1;
          else       state_d = nxt;
        end else if (stat_i.done) begin
          wait_d  = 1'b0;
          state_d = nxt;
        end
      end
    endcase
    cmd_o.start = issue;
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      wait_q  <= 1'b0;
      ov_q    <= 1'b0;
      fin_q   <= rau_pkg::FK_NONE;
    end else begin
      state_q <= state_d;
      wait_q  <= wait_d;
      ov_q    <= ov_d;
      fin_q   <= fin_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = ov_q;

endmodule

FILE: sv/rational_arith_unit_core.sv
`timescale 1ns / 1ps
// An undefined command or a zero denominator goes from the check straight to the final
// step; otherwise the run is set by the bit-serial gcd (one step per cycle) and the
// 64-step dual divider, run two to four times.
// Throughput: one request at a time; the next is taken once the previous one's
// result is registered, even while that result still waits to be taken.
// Reset: rst_ni clears the sequencer and the output valid.
module rational_arith_unit_core #(
  parameter int WIDTH = rau_pkg::DefWidth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // cmd[2:0], a_num[34:3], a_den[66:35], b_num[98:67], b_den[130:99], zero pad
  input  logic [rau_pkg::InDataW-1:0]   s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // res_num[31:0], res_den[62:32], order[64:63], status[66:65], zero pad
  output logic [rau_pkg::OutDataW-1:0]  m_axis_tdata_o
);

  rau_pkg::dp_cmd_t  cmd;
  rau_pkg::dp_stat_t stat;

  rau_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  rau_datapath #(.WIDTH(WIDTH)) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .in_data_i (s_axis_tdata_i),
    .out_data_o(m_axis_tdata_o)
  );

endmodule
